// File: design/gpe_pkg.sv
// Shared constants and types of the glare PSF evaluator.
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

  // Field widths.
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned DEG_W   = 40;

  // Radians to degrees: 180/pi in Q26, rounded into Q32 degrees.
  localparam logic [31:0] DEG_K   = 32'd3845054675;
  localparam logic [64:0] DEG_RND = 65'd8388608;

  // 0.02 degrees in Q32.
  localparam logic [39:0] OFS_002 = 40'd85899346;

  // Gaussian term.
  localparam int unsigned EXP_BITS    = 49;
  localparam int unsigned QW          = 63;
  localparam int unsigned SERIES_LAST = 44;
  localparam logic [62:0] ONE_Q62     = {1'b1, 62'b0};
  localparam logic [61:0] GAUSS_K     = 62'd2500;
  localparam logic [61:0] GAUSS_RND   = 62'd2048;
  localparam logic [19:0] C0_INT      = 20'd1002240;
  localparam int unsigned T0_W        = 45;

  // Reciprocal terms: weights in Q40 and the starting remainders of the dividers.
  localparam logic [43:0]  C1_Q40    = 44'd10989596729389;
  localparam logic [43:0]  C2_Q40    = 44'd10980888597297;
  localparam int unsigned  DIV_STEPS = 45;
  localparam int unsigned  E2_W      = 80;
  localparam int unsigned  E3_W      = 120;
  localparam int unsigned  T12_W     = 46;
  localparam logic [119:0] DIV1_INIT = {41'b0, C1_Q40, 35'b0};
  localparam logic [79:0]  DIV2_INIT = {33'b0, C2_Q40, 3'b0};

  // Pipeline timing.
  localparam int unsigned GAUSS_LAT = 2 * EXP_BITS + 4;
  localparam int unsigned RECIP_LAT = DIV_STEPS + 6;
  localparam int unsigned ALIGN_LAT = GAUSS_LAT - RECIP_LAT;
  localparam int unsigned PIPE_LAT  = GAUSS_LAT + 2;

  localparam logic [47:0] OUT_MAX = {48{1'b1}};

  typedef logic [61:0] tab_entry_t;

  typedef enum logic [2:0] {
    TB_SETUP,
    TB_DIVIDE,
    TB_ACCUM,
    TB_SQUARE,
    TB_ROUND,
    TB_DONE
  } tb_state_e;

endpackage

`default_nettype wire

// File: design/glare_psf_evaluator_top.sv
// Top level of the photopic glare PSF evaluator.
//
//   Channel   Direction  Handshake                 Word
//   command   in         start high, busy low      angle_i, Q2.30 radians
//   result    out        done_o strobe, one cycle  psf_value_o, Q24.24
//
// One word is taken every cycle while busy is low; each result passes through
// the 49 two-stage Q62 factor multiplies of the exponential.
// After reset busy stays high while the exponential table is built by a
// serial divider, one series term after another, followed by repeated squaring.
// The result side cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module glare_psf_evaluator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] angle_i,
  output logic [47:0]      psf_value_o,
  output logic             done_o
);

  localparam int unsigned LAT = gpe_pkg::PIPE_LAT;
  localparam int unsigned AL  = gpe_pkg::ALIGN_LAT;

  logic                      accept;
  logic                      tab_ready;
  gpe_pkg::tab_entry_t       tab [gpe_pkg::EXP_BITS];
  logic [64:0]               deg_prod;
  logic [39:0]               d_q;
  logic [LAT-1:0]            vld_q;
  logic [gpe_pkg::T0_W-1:0]  t0;
  logic [gpe_pkg::T12_W-1:0] t12;
  logic [gpe_pkg::T12_W-1:0] t12_dly_q [AL];
  logic [48:0]               total;
  logic [47:0]               psf_q;

  assign accept = start && !busy;
  assign busy   = !tab_ready;

  gpe_exp_table u_exp_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ready_o (tab_ready),
    .tab_o   (tab)
  );

  // Radians to Q32 degrees.
  assign deg_prod = 65'(angle_i) * 65'(gpe_pkg::DEG_K) + gpe_pkg::DEG_RND;
  always_ff @(posedge clk_i) begin
    d_q <= deg_prod[63:24];
  end

  // Valid bits follow each word down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  gpe_gauss u_gauss (
    .clk_i (clk_i),
    .d_i   (d_q),
    .tab_i (tab),
    .t0_o  (t0)
  );

  gpe_recip u_recip (
    .clk_i (clk_i),
    .d_i   (d_q),
    .t12_o (t12)
  );

  // Delay the reciprocal terms to meet the Gaussian term.
  always_ff @(posedge clk_i) begin
    t12_dly_q[0] <= t12;
    for (int i = 1; i < AL; i++) begin
      t12_dly_q[i] <= t12_dly_q[i-1];
    end
  end

  // Final sum with saturation.
  assign total = 49'(t0) + 49'(t12_dly_q[AL-1]);
  always_ff @(posedge clk_i) begin
    psf_q <= total[48] ? gpe_pkg::OUT_MAX : total[47:0];
  end

  assign psf_value_o = psf_q;
  assign done_o      = vld_q[LAT-1];

endmodule

`default_nettype wire

// File: design/gpe_exp_table.sv
// Builds the table of exp(-2^(p-44)) factors in Q62 after reset.
`timescale 1ns / 1ps
`default_nettype none

module gpe_exp_table (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  output logic            ready_o,
  output gpe_pkg::tab_entry_t tab_o [gpe_pkg::EXP_BITS]
);

  localparam logic [5:0] DIV_LAST    = 6'(gpe_pkg::QW - 1);
  localparam logic [5:0] N_LAST      = 6'd63;
  localparam logic [5:0] K_LAST      = 6'(gpe_pkg::SERIES_LAST);
  localparam logic [2:0] SQ_LAST     = 3'(gpe_pkg::EXP_BITS - gpe_pkg::SERIES_LAST - 1);
  localparam logic [124:0] ROUND61   = 125'd1 << 61;

  gpe_pkg::tb_state_e state_q, state_d;
  logic [5:0]   k_q, k_d, n_q, n_d, cnt_q, cnt_d;
  logic [2:0]   sqc_q, sqc_d;
  logic [1:0]   sqi_q, sqi_d;
  logic [62:0]  term_q, term_d, sum_q, sum_d, num_q, num_d, quo_q, quo_d;
  logic [5:0]   rem_q, rem_d;
  logic [124:0] acc_q, acc_d;
  logic [61:0]  last_q, last_d;
  gpe_pkg::tab_entry_t tab_q [gpe_pkg::EXP_BITS];

  logic [6:0]   trial, trial_sub;
  logic         ge;
  logic [62:0]  sum_new;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [124:0] pp_sh, rnd;
  logic         we;
  logic [5:0]   waddr;
  logic [61:0]  wdata;

  // One step of the restoring divide by the series index.
  assign trial     = {rem_q, num_q[62]};
  assign ge        = trial >= {1'b0, n_q};
  assign trial_sub = trial - {1'b0, n_q};

  // Alternating series: odd terms subtract, even terms add.
  assign sum_new = (quo_q == '0) ? sum_q : (n_q[0] ? (sum_q - quo_q) : (sum_q + quo_q));

  // Squaring runs on 32-bit halves, one partial product a cycle.
  assign op_a   = sqi_q[1] ? {2'b0, last_q[61:32]} : last_q[31:0];
  assign op_b   = sqi_q[0] ? {2'b0, last_q[61:32]} : last_q[31:0];
  assign pp     = 64'(op_a) * 64'(op_b);
  assign pp_pos = {sqi_q[1] & sqi_q[0], sqi_q[1] ^ sqi_q[0]};
  assign pp_sh  = {61'b0, pp} << {pp_pos, 5'b0};
  assign rnd    = acc_q + ROUND61;

  // Sequencer for the series, the squarings and the table writes.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    sqc_d   = sqc_q;
    sqi_d   = sqi_q;
    term_d  = term_q;
    sum_d   = sum_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    last_d  = last_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    case (state_q)
      gpe_pkg::TB_SETUP: begin
        num_d   = term_q >> k_q;
        quo_d   = '0;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = gpe_pkg::TB_DIVIDE;
      end
      gpe_pkg::TB_DIVIDE: begin
        num_d = {num_q[61:0], 1'b0};
        rem_d = ge ? trial_sub[5:0] : trial[5:0];
        quo_d = {quo_q[61:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = gpe_pkg::TB_ACCUM;
        end
      end
      gpe_pkg::TB_ACCUM: begin
        if (quo_q == '0 || n_q == N_LAST) begin
          we    = 1'b1;
          waddr = K_LAST - k_q;
          wdata = sum_new[61:0];
          if (k_q == 6'd1) begin
            last_d = sum_new[61:0];
          end
          if (k_q == K_LAST) begin
            sqc_d   = '0;
            sqi_d   = '0;
            acc_d   = '0;
            state_d = gpe_pkg::TB_SQUARE;
          end else begin
            k_d     = k_q + 6'd1;
            n_d     = 6'd1;
            term_d  = gpe_pkg::ONE_Q62;
            sum_d   = gpe_pkg::ONE_Q62;
            state_d = gpe_pkg::TB_SETUP;
          end
        end else begin
          sum_d   = sum_new;
          term_d  = quo_q;
          n_d     = n_q + 6'd1;
          state_d = gpe_pkg::TB_SETUP;
        end
      end
      gpe_pkg::TB_SQUARE: begin
        acc_d = acc_q + pp_sh;
        sqi_d = sqi_q + 2'd1;
        if (sqi_q == 2'd3) begin
          state_d = gpe_pkg::TB_ROUND;
        end
      end
      gpe_pkg::TB_ROUND: begin
        we     = 1'b1;
        waddr  = K_LAST + {3'b0, sqc_q};
        wdata  = rnd[123:62];
        last_d = rnd[123:62];
        if (sqc_q == SQ_LAST) begin
          state_d = gpe_pkg::TB_DONE;
        end else begin
          sqc_d   = sqc_q + 3'd1;
          sqi_d   = '0;
          acc_d   = '0;
          state_d = gpe_pkg::TB_SQUARE;
        end
      end
      gpe_pkg::TB_DONE: begin
        state_d = gpe_pkg::TB_DONE;
      end
      default: begin
        state_d = gpe_pkg::TB_SETUP;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpe_pkg::TB_SETUP;
      k_q     <= 6'd1;
      n_q     <= 6'd1;
      cnt_q   <= '0;
      sqc_q   <= '0;
      sqi_q   <= '0;
      term_q  <= gpe_pkg::ONE_Q62;
      sum_q   <= gpe_pkg::ONE_Q62;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      sqc_q   <= sqc_d;
      sqi_q   <= sqi_d;
      term_q  <= term_d;
      sum_q   <= sum_d;
    end
  end

  // Datapath registers and the table itself.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    last_q <= last_d;
    if (we) begin
      tab_q[waddr] <= wdata;
    end
  end

  assign ready_o = (state_q == gpe_pkg::TB_DONE);
  assign tab_o   = tab_q;

endmodule

`default_nettype wire

// File: design/gpe_gauss.sv
// Pipeline for the Gaussian term 0.384*2.61e6*exp(-2500*d^2).
`timescale 1ns / 1ps
`default_nettype none

module gpe_gauss (
  input  wire logic                 clk_i,
  input  wire logic [39:0]          d_i,
  input  gpe_pkg::tab_entry_t       tab_i [gpe_pkg::EXP_BITS],
  output logic [gpe_pkg::T0_W-1:0]  t0_o
);

  localparam int unsigned NB = gpe_pkg::EXP_BITS;
  localparam logic [125:0] ROUND61 = 126'd1 << 61;
  localparam logic [83:0]  ROUND37 = 84'd1 << 37;

  logic [28:0]   d_lo;
  logic          small_q;
  logic [57:0]   sq_q;
  logic [61:0]   scaled;
  logic [NB-1:0] u_q;
  logic          zero_q;

  // Square of the angle in degrees; large angles give zero.
  assign d_lo = d_i[28:0];
  always_ff @(posedge clk_i) begin
    small_q <= (d_i[39:29] == '0);
    sq_q    <= 58'(d_lo) * 58'(d_lo);
  end

  // Exponent argument 2500*d^2 in Q44.
  assign scaled = 62'(sq_q[57:8]) * gpe_pkg::GAUSS_K + gpe_pkg::GAUSS_RND;
  always_ff @(posedge clk_i) begin
    u_q    <= scaled[60:12];
    zero_q <= !small_q || scaled[61];
  end

  logic [62:0]   e_in [NB];
  logic [NB-1:0] u_in [NB];
  logic          z_in [NB];
  logic [62:0]   e_q  [NB];
  logic [NB-1:0] ub_q [NB];
  logic          zb_q [NB];

  // One factor of the exponential per pair of stages, in bit order.
  for (genvar p = 0; p < NB; p++) begin : g_factor
    logic [62:0]   f;
    logic [63:0]   ll_q;
    logic [62:0]   lh_q, hl_q;
    logic [61:0]   hh_q;
    logic [NB-1:0] ua_q;
    logic          za_q;
    logic [125:0]  full;

    if (p == 0) begin : g_first
      assign e_in[p] = gpe_pkg::ONE_Q62;
      assign u_in[p] = u_q;
      assign z_in[p] = zero_q;
    end else begin : g_next
      assign e_in[p] = e_q[p-1];
      assign u_in[p] = ub_q[p-1];
      assign z_in[p] = zb_q[p-1];
    end

    // A clear bit multiplies by one, which rounds back to the same value.
    assign f = u_in[p][p] ? {1'b0, tab_i[p]} : gpe_pkg::ONE_Q62;

    // Partial products on 32-bit halves.
    always_ff @(posedge clk_i) begin
      ll_q <= 64'(e_in[p][31:0]) * 64'(f[31:0]);
      lh_q <= 63'(e_in[p][31:0]) * 63'(f[62:32]);
      hl_q <= 63'(e_in[p][62:32]) * 63'(f[31:0]);
      hh_q <= 62'(e_in[p][62:32]) * 62'(f[62:32]);
      ua_q <= u_in[p];
      za_q <= z_in[p];
    end

    // Sum of the partial products, rounded to Q62.
    assign full = 126'(ll_q) + (126'(lh_q) << 32) + (126'(hl_q) << 32)
                + (126'(hh_q) << 64) + ROUND61;
    always_ff @(posedge clk_i) begin
      e_q[p]  <= full[124:62];
      ub_q[p] <= ua_q;
      zb_q[p] <= za_q;
    end
  end

  logic [51:0] pl_q;
  logic [50:0] ph_q;
  logic        zf_q;
  logic [83:0] t_sum;
  logic [gpe_pkg::T0_W-1:0] t0_q;

  // Weight and scale into Q24.24.
  always_ff @(posedge clk_i) begin
    pl_q <= 52'(e_q[NB-1][31:0]) * 52'(gpe_pkg::C0_INT);
    ph_q <= 51'(e_q[NB-1][62:32]) * 51'(gpe_pkg::C0_INT);
    zf_q <= zb_q[NB-1];
  end

  assign t_sum = 84'(pl_q) + (84'(ph_q) << 32) + ROUND37;
  always_ff @(posedge clk_i) begin
    t0_q <= zf_q ? '0 : t_sum[82:38];
  end

  assign t0_o = t0_q;

endmodule

`default_nettype wire

// File: design/gpe_recip.sv
// Pipeline for the two reciprocal terms, dividing by (d+0.02)^3 and (d+0.02)^2.
`timescale 1ns / 1ps
`default_nettype none

module gpe_recip (
  input  wire logic                  clk_i,
  input  wire logic [39:0]           d_i,
  output logic [gpe_pkg::T12_W-1:0]  t12_o
);

  localparam int unsigned NS  = gpe_pkg::DIV_STEPS;
  localparam int unsigned W3  = gpe_pkg::E3_W;
  localparam int unsigned W2  = gpe_pkg::E2_W;

  logic [39:0] e_q, e_s2_q, e_s3_q;
  logic [39:0] p00_q, p01_q, p11_q;
  logic [W2-1:0] e2_q, e2_s4_q, e2_s5_q;
  logic [39:0] m_q [4][2];
  logic [W3-1:0] e3_sum, e3_q;

  // Shifted angle.
  always_ff @(posedge clk_i) begin
    e_q <= d_i + gpe_pkg::OFS_002;
  end

  // Square from 20-bit halves.
  always_ff @(posedge clk_i) begin
    p00_q  <= 40'(e_q[19:0]) * 40'(e_q[19:0]);
    p01_q  <= 40'(e_q[19:0]) * 40'(e_q[39:20]);
    p11_q  <= 40'(e_q[39:20]) * 40'(e_q[39:20]);
    e_s2_q <= e_q;
  end

  always_ff @(posedge clk_i) begin
    e2_q   <= W2'(p00_q) + (W2'(p01_q) << 21) + (W2'(p11_q) << 40);
    e_s3_q <= e_s2_q;
  end

  // Cube from 20-bit pieces of the square and the shifted angle.
  for (genvar i = 0; i < 4; i++) begin : g_cube_row
    for (genvar j = 0; j < 2; j++) begin : g_cube_col
      always_ff @(posedge clk_i) begin
        m_q[i][j] <= 40'(e2_q[20*i +: 20]) * 40'(e_s3_q[20*j +: 20]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e2_s4_q <= e2_q;
  end

  always_comb begin
    e3_sum = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        e3_sum = e3_sum + (W3'(m_q[i][j]) << (20 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e3_q    <= e3_sum;
    e2_s5_q <= e2_s4_q;
  end

  logic [W3-1:0] r1_in [NS];
  logic [W3-1:0] v1_in [NS];
  logic [NS-1:0] q1_in [NS];
  logic [W3-1:0] r1_q  [NS];
  logic [W3-1:0] v1_q  [NS];
  logic [NS-1:0] q1_q  [NS];
  logic [W2-1:0] r2_in [NS];
  logic [W2-1:0] v2_in [NS];
  logic [NS-1:0] q2_in [NS];
  logic [W2-1:0] r2_q  [NS];
  logic [W2-1:0] v2_q  [NS];
  logic [NS-1:0] q2_q  [NS];

  // Restoring dividers, one quotient bit per stage for both terms.
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [W3:0] trial1, diff1;
    logic        ge1;
    logic [W2:0] trial2, diff2;
    logic        ge2;

    if (s == 0) begin : g_first
      assign r1_in[s] = gpe_pkg::DIV1_INIT;
      assign v1_in[s] = e3_q;
      assign q1_in[s] = '0;
      assign r2_in[s] = gpe_pkg::DIV2_INIT;
      assign v2_in[s] = e2_s5_q;
      assign q2_in[s] = '0;
    end else begin : g_next
      assign r1_in[s] = r1_q[s-1];
      assign v1_in[s] = v1_q[s-1];
      assign q1_in[s] = q1_q[s-1];
      assign r2_in[s] = r2_q[s-1];
      assign v2_in[s] = v2_q[s-1];
      assign q2_in[s] = q2_q[s-1];
    end

    assign trial1 = {r1_in[s], 1'b0};
    assign ge1    = trial1 >= {1'b0, v1_in[s]};
    assign diff1  = trial1 - {1'b0, v1_in[s]};
    assign trial2 = {r2_in[s], 1'b0};
    assign ge2    = trial2 >= {1'b0, v2_in[s]};
    assign diff2  = trial2 - {1'b0, v2_in[s]};

    always_ff @(posedge clk_i) begin
      r1_q[s] <= ge1 ? diff1[W3-1:0] : trial1[W3-1:0];
      v1_q[s] <= v1_in[s];
      q1_q[s] <= {q1_in[s][NS-2:0], ge1};
      r2_q[s] <= ge2 ? diff2[W2-1:0] : trial2[W2-1:0];
      v2_q[s] <= v2_in[s];
      q2_q[s] <= {q2_in[s][NS-2:0], ge2};
    end
  end

  logic [gpe_pkg::T12_W-1:0] t12_q;

  // Sum of the two reciprocal terms.
  always_ff @(posedge clk_i) begin
    t12_q <= gpe_pkg::T12_W'(q1_q[NS-1]) + gpe_pkg::T12_W'(q2_q[NS-1]);
  end

  assign t12_o = t12_q;

endmodule

`default_nettype wire

// File: design/gpe_checker.sv
// Port-level checks of the glare PSF evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] angle_i,
  input wire logic [47:0] psf_value_o,
  input wire logic        done_o
);

  localparam int unsigned LAT = gpe_pkg::PIPE_LAT;

  // Every result follows a command by exactly the pipeline latency.
  a_done_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without a command at the pipeline latency");

  // Once the table is built the block stays ready.
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose again after the table was built");

  // Results only appear once the block is ready.
  a_done_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while the table is still being built");

  // The block keeps no state: equal angles back to back give equal results.
  a_same_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && ($past(angle_i, LAT) == $past(angle_i, LAT + 1)))
    |-> $stable(psf_value_o))
    else $error("equal angles gave different results");

endmodule

bind glare_psf_evaluator_top gpe_checker u_checker (.*);

`default_nettype wire
